/* rtl/core/assert_macros.svh */
// Assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("%m");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/bsa_pkg.sv */
// ----------------------------------------------------------------------------
// bsa_pkg
// Types and constants for the block status allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;
    localparam int MAX_BLOCKS = 64;
    localparam int MAX_SLOTS  = 8;
    localparam int BW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = $clog2(MAX_SLOTS);

    localparam logic [2:0] ST_EMPTY  = 3'd0;
    localparam logic [2:0] ST_APPEND = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_MFROM  = 3'd3;
    localparam logic [2:0] ST_MTO    = 3'd4;

    localparam logic [3:0] ACT_ALLOC  = 4'd0;
    localparam logic [3:0] ACT_FREE   = 4'd1;
    localparam logic [3:0] ACT_UNWR   = 4'd2;
    localparam logic [3:0] ACT_APPEND = 4'd3;
    localparam logic [3:0] ACT_SLOT   = 4'd4;
    localparam logic [3:0] ACT_MFROM  = 4'd5;
    localparam logic [3:0] ACT_MTO    = 4'd6;
    localparam logic [3:0] ACT_CLRW   = 4'd7;
    localparam logic [3:0] ACT_UPDATE = 4'd8;

    localparam logic [1:0] RC_OK   = 2'd0;
    localparam logic [1:0] RC_NONE = 2'd1;
    localparam logic [1:0] RC_BAD  = 2'd2;

    localparam logic [6:0] RATIO_MAX  = 7'd100;
    localparam logic [6:0] RATIO_LIM  = 7'd99;
endpackage

/* rtl/core/block_status_allocator.sv */
// ----------------------------------------------------------------------------
// block_status_allocator
// Block table with allocate, free, append, slot, merge, write-mark and update actions.
// ----------------------------------------------------------------------------
// One transfer in gives one result. Each searching action walks the block table
// one entry at a time through a single compare unit. The table has one registered
// read port, so each entry visited is first addressed and its returned data is
// then compared. Actions that fall back to allocation scan twice, the second time
// for an empty block. Slot append can add up to eight slot compares for each
// append block cached by another slot. Free and update need no scan, and clear
// writing steps through each entry in use. The input is not ready while an action
// runs or while its result waits on the output register. Table entries past
// block_count are not cleared at reset; growing the table initializes each entry
// as it comes into use.
`include "assert_macros.svh"
module block_status_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[3:0], block_id[9:4], slot[12:10], mem_enough[13], new_status[16:14],
    // use_ratio[23:17]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_code[1:0], block_index[7:2], block_count[14:8]
    output logic [15:0] m_axis_tdata
);
    localparam int BW = bsa_pkg::BW;
    localparam int CW = bsa_pkg::CW;
    localparam int SW = bsa_pkg::SW;

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_ALLOC, S_ROT, S_SLOTCHK, S_MFSCAN, S_CLR, S_DONE
    } t_state;

    t_state r_state;
    logic [3:0]  r_cfg;
    logic [2:0]  r_status [bsa_pkg::MAX_BLOCKS];
    logic        r_wmark  [bsa_pkg::MAX_BLOCKS];
    logic [6:0]  r_ratio  [bsa_pkg::MAX_BLOCKS];
    logic [BW-1:0] r_sblk [bsa_pkg::MAX_SLOTS];
    logic        r_svalid [bsa_pkg::MAX_SLOTS];
    logic [CW-1:0] r_count;
    logic [BW-1:0] r_start;

    logic [3:0]  r_act;
    logic [BW-1:0] r_bid;
    logic [SW-1:0] r_slot;
    logic        r_mem;
    logic [2:0]  r_nst;
    logic [6:0]  r_nratio;
    logic [2:0]  r_want;     // status sought by a linear scan
    logic [CW-1:0] r_i;      // scan step
    logic [BW-1:0] r_j;      // rotating candidate
    logic [SW:0] r_k;        // slot compare index
    logic [SW:0] r_nslots;
    logic [6:0]  r_least;
    logic        r_found;
    logic [BW-1:0] r_pick;
    logic        r_ovalid;
    logic [1:0]  r_code;
    logic [BW-1:0] r_idx;
    logic        r_ph;       // read data valid for the current address
    logic [2:0]  r_rd_status;
    logic        r_rd_wmark;
    logic [6:0]  r_rd_ratio;

    logic [SW:0] slots_use;
    always_comb begin
        if (r_cfg < 4'd2) slots_use = (SW+1)'(2);
        else if (32'(r_cfg) > bsa_pkg::MAX_SLOTS) slots_use = (SW+1)'(bsa_pkg::MAX_SLOTS);
        else slots_use = (SW+1)'(r_cfg);
    end

    logic [BW-1:0] scan_i;
    assign scan_i = r_i[BW-1:0];
    logic [CW-1:0] next_j;
    assign next_j = (CW'(r_j) + 1'b1 >= r_count) ? '0 : CW'(r_j) + 1'b1;

    logic [BW-1:0] rd_addr;
    always_comb begin
        unique case (r_state)
            S_ROT:     rd_addr = r_j;
            S_SLOTCHK: rd_addr = r_found ? r_j : r_sblk[r_slot];
            default:   rd_addr = scan_i;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_status <= r_status[rd_addr];
        r_rd_wmark  <= r_wmark[rd_addr];
        r_rd_ratio  <= r_ratio[rd_addr];
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, 7'(r_count), r_idx, r_code};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= 4'd2;
            r_count <= '0;
            r_start <= '0;
            r_ovalid <= 1'b0;
            for (int n = 0; n < bsa_pkg::MAX_SLOTS; n++) begin
                r_svalid[n] <= 1'b0;
                r_sblk[n]   <= '0;
            end
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_act    <= s_axis_tdata[3:0];
                        r_bid    <= s_axis_tdata[9:4];
                        r_slot   <= s_axis_tdata[12:10];
                        r_mem    <= s_axis_tdata[13];
                        r_nst    <= s_axis_tdata[16:14];
                        r_nratio <= s_axis_tdata[23:17];
                        r_i      <= '0;
                        r_ph     <= 1'b0;
                        r_found  <= 1'b0;
                        r_least  <= bsa_pkg::RATIO_MAX;
                        r_nslots <= slots_use;
                        r_code   <= bsa_pkg::RC_NONE;
                        r_idx    <= '0;
                        unique case (s_axis_tdata[3:0])
                            bsa_pkg::ACT_ALLOC: begin
                                r_want <= bsa_pkg::ST_EMPTY; r_state <= S_FIND;
                            end
                            bsa_pkg::ACT_UNWR: begin
                                r_want <= bsa_pkg::ST_APPEND; r_state <= S_FIND;
                            end
                            bsa_pkg::ACT_MFROM: begin
                                r_want <= bsa_pkg::ST_MFROM; r_state <= S_FIND;
                            end
                            bsa_pkg::ACT_MTO: begin
                                r_want <= bsa_pkg::ST_MTO; r_state <= S_FIND;
                            end
                            bsa_pkg::ACT_APPEND: begin
                                r_j <= r_start; r_state <= S_ROT;
                            end
                            bsa_pkg::ACT_SLOT: begin
                                r_j <= r_start; r_state <= S_SLOTCHK;
                            end
                            bsa_pkg::ACT_CLRW: r_state <= S_CLR;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_FIND: begin
                    // linear scan for first block of the sought status
                    if (r_i >= r_count) begin
                        r_ph <= 1'b0;
                        if (r_act == bsa_pkg::ACT_MFROM) begin
                            r_i <= '0; r_state <= S_MFSCAN;
                        end else begin
                            r_state <= S_ALLOC;
                        end
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (r_rd_status == r_want &&
                                 !(r_act == bsa_pkg::ACT_UNWR &&
                                   r_want == bsa_pkg::ST_APPEND && r_rd_wmark)) begin
                        if (r_want == bsa_pkg::ST_EMPTY) begin
                            // reused empty block, finished like a grown one
                            r_pick  <= scan_i;
                            r_found <= 1'b1;
                        end else begin
                            r_code <= bsa_pkg::RC_OK;
                            r_idx  <= scan_i;
                            if (r_act == bsa_pkg::ACT_UNWR) r_wmark[scan_i] <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_i <= r_i + 1'b1; r_ph <= 1'b0;
                    end
                end
                S_ALLOC: begin
                    // r_want==EMPTY means the empty scan already ran
                    if (r_want != bsa_pkg::ST_EMPTY) begin
                        r_want <= bsa_pkg::ST_EMPTY;
                        r_i <= '0;
                        r_ph <= 1'b0;
                        r_state <= S_FIND;
                    end else begin
                        r_state <= S_DONE;
                        if (32'(r_count) < bsa_pkg::MAX_BLOCKS &&
                            (r_mem || r_act == bsa_pkg::ACT_MTO)) begin
                            r_status[r_count[BW-1:0]] <= bsa_pkg::ST_EMPTY;
                            r_wmark[r_count[BW-1:0]]  <= 1'b0;
                            r_ratio[r_count[BW-1:0]]  <= '0;
                            r_count <= r_count + 1'b1;
                            r_pick  <= r_count[BW-1:0];
                            r_found <= 1'b1;
                        end
                    end
                end
                S_ROT: begin
                    if (r_i >= r_count) begin
                        r_want <= bsa_pkg::ST_APPEND; r_ph <= 1'b0; r_state <= S_ALLOC;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (r_rd_status == bsa_pkg::ST_APPEND) begin
                        r_code <= bsa_pkg::RC_OK; r_idx <= r_j;
                        r_start <= r_j; r_state <= S_DONE;
                    end else begin
                        r_j <= next_j[BW-1:0]; r_i <= r_i + 1'b1; r_ph <= 1'b0;
                    end
                end
                S_SLOTCHK: begin
                    // first pass: range and cached entry; then rotating
                    // search with one slot compare per cycle
                    if (!r_found) begin
                        if ({1'b0, r_slot} >= r_nslots) begin
                            r_code <= bsa_pkg::RC_BAD; r_state <= S_DONE;
                        end else if (!r_ph) begin
                            r_ph <= 1'b1;
                        end else if (r_svalid[r_slot] && CW'(r_sblk[r_slot]) < r_count &&
                                     r_rd_status == bsa_pkg::ST_APPEND) begin
                            r_code <= bsa_pkg::RC_OK; r_idx <= r_sblk[r_slot];
                            r_state <= S_DONE;
                        end else begin
                            r_svalid[r_slot] <= 1'b0;
                            r_found <= 1'b1;
                            r_k <= '0;
                            r_ph <= 1'b0;
                        end
                    end else if (r_i >= r_count) begin
                        r_found <= 1'b0; r_ph <= 1'b0;
                        r_want <= bsa_pkg::ST_APPEND; r_state <= S_ALLOC;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (r_rd_status != bsa_pkg::ST_APPEND) begin
                        r_j <= next_j[BW-1:0]; r_i <= r_i + 1'b1; r_ph <= 1'b0;
                    end else if (r_k >= r_nslots) begin
                        r_code <= bsa_pkg::RC_OK; r_idx <= r_j;
                        r_sblk[r_slot] <= r_j; r_svalid[r_slot] <= 1'b1;
                        r_found <= 1'b0;
                        r_state <= S_DONE;
                    end else if (r_svalid[r_k[SW-1:0]] && r_sblk[r_k[SW-1:0]] == r_j) begin
                        r_k <= '0; r_j <= next_j[BW-1:0]; r_i <= r_i + 1'b1; r_ph <= 1'b0;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_MFSCAN: begin
                    // once r_found is set, r_least holds the ratio of r_pick
                    if (r_i >= r_count) begin
                        if (r_found && r_least < bsa_pkg::RATIO_LIM) begin
                            r_status[r_pick] <= bsa_pkg::ST_MFROM;
                            r_code <= bsa_pkg::RC_OK; r_idx <= r_pick;
                        end
                        r_found <= 1'b0;
                        r_state <= S_DONE;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        if (r_rd_status == bsa_pkg::ST_FULL && r_rd_ratio <= r_least) begin
                            r_least <= r_rd_ratio; r_pick <= scan_i; r_found <= 1'b1;
                        end
                        r_i <= r_i + 1'b1; r_ph <= 1'b0;
                    end
                end
                S_CLR: begin
                    if (r_i >= r_count) begin
                        r_code <= bsa_pkg::RC_OK; r_state <= S_DONE;
                    end else begin
                        r_wmark[scan_i] <= 1'b0; r_i <= r_i + 1'b1;
                    end
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                    if (r_act == bsa_pkg::ACT_FREE) begin
                        if (CW'(r_bid) >= r_count) r_code <= bsa_pkg::RC_BAD;
                        else begin
                            r_status[r_bid] <= bsa_pkg::ST_EMPTY; r_ratio[r_bid] <= '0;
                            r_code <= bsa_pkg::RC_OK; r_idx <= r_bid;
                        end
                    end else if (r_act == bsa_pkg::ACT_UPDATE) begin
                        if (CW'(r_bid) >= r_count || r_nst > bsa_pkg::ST_MTO)
                            r_code <= bsa_pkg::RC_BAD;
                        else begin
                            r_status[r_bid] <= r_nst;
                            r_ratio[r_bid] <= (r_nratio > bsa_pkg::RATIO_MAX) ?
                                              bsa_pkg::RATIO_MAX : r_nratio;
                            r_code <= bsa_pkg::RC_OK; r_idx <= r_bid;
                        end
                    end else if (r_found && r_act != bsa_pkg::ACT_MFROM) begin
                        // allocated block, reused or grown
                        r_code <= bsa_pkg::RC_OK; r_idx <= r_pick;
                        unique case (r_act)
                            bsa_pkg::ACT_UNWR: begin
                                r_status[r_pick] <= bsa_pkg::ST_APPEND;
                                r_wmark[r_pick] <= 1'b1;
                            end
                            bsa_pkg::ACT_APPEND: begin
                                r_status[r_pick] <= bsa_pkg::ST_APPEND; r_start <= r_pick;
                            end
                            bsa_pkg::ACT_SLOT: begin
                                r_status[r_pick] <= bsa_pkg::ST_APPEND; r_start <= r_pick;
                                r_sblk[r_slot] <= r_pick; r_svalid[r_slot] <= 1'b1;
                            end
                            bsa_pkg::ACT_MTO: r_status[r_pick] <= bsa_pkg::ST_MTO;
                            default: ;
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ASSERT_CLK(a_count_max, i_clk, i_rst_n, 32'(r_count) <= bsa_pkg::MAX_BLOCKS)
    `ASSERT_NEXT(a_done_out, i_clk, i_rst_n, r_state == S_DONE, r_ovalid)
endmodule

/* tb/block_status_allocator_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_status_allocator_checker
// Watches the input, output and register ports of the allocator. It keeps its
// own copy of the block table, works out the result of each accepted action
// and compares it with the result transfers in order.
// ----------------------------------------------------------------------------
module block_status_allocator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    logic [3:0]  slot_reg;
    logic [6:0]  nblocks;
    logic [2:0]  status_tbl [bsa_pkg::MAX_BLOCKS];
    logic        writing    [bsa_pkg::MAX_BLOCKS];
    logic [6:0]  ratio_tbl  [bsa_pkg::MAX_BLOCKS];
    logic [5:0]  slot_blk   [bsa_pkg::MAX_SLOTS];
    logic        slot_vld   [bsa_pkg::MAX_SLOTS];
    logic [5:0]  rot_start;
    logic [15:0] expected_results [$];

    function automatic int active_slots();
        if (slot_reg < 2) return 2;
        if (slot_reg > bsa_pkg::MAX_SLOTS) return bsa_pkg::MAX_SLOTS;
        return slot_reg;
    endfunction

    function automatic int first_with(logic [2:0] st);
        for (int i = 0; i < nblocks; i++)
            if (status_tbl[i] == st) return i;
        return -1;
    endfunction

    function automatic int take_block(bit mem_check, bit mem_ok);
        int b;
        b = first_with(bsa_pkg::ST_EMPTY);
        if (b >= 0) return b;
        if (nblocks >= bsa_pkg::MAX_BLOCKS || (mem_check && !mem_ok)) return -1;
        b = nblocks;
        status_tbl[b] = bsa_pkg::ST_EMPTY;
        writing[b] = 1'b0;
        ratio_tbl[b] = '0;
        nblocks = nblocks + 1;
        return b;
    endfunction

    function automatic bit held_by_slot(int j, int n);
        for (int i = 0; i < n; i++)
            if (slot_vld[i] && slot_blk[i] == j) return 1'b1;
        return 1'b0;
    endfunction

    function automatic int next_append(bit skip, int n);
        int j;
        for (int i = 0; i < nblocks; i++) begin
            j = (rot_start + i) % nblocks;
            if (status_tbl[j] == bsa_pkg::ST_APPEND && !(skip && held_by_slot(j, n))) return j;
        end
        return -1;
    endfunction

    function automatic logic [15:0] apply_action(logic [23:0] d);
        logic [3:0] act;
        logic [5:0] bid;
        logic [2:0] slot, nst;
        logic       mem;
        logic [6:0] ratio;
        logic [1:0] code;
        int         b, n, pick, least;
        act = d[3:0];
        bid = d[9:4];
        slot = d[12:10];
        mem = d[13];
        nst = d[16:14];
        ratio = d[23:17];
        code = bsa_pkg::RC_NONE;
        b = -1;
        case (act)
            bsa_pkg::ACT_ALLOC: begin
                b = take_block(1'b1, mem);
            end
            bsa_pkg::ACT_FREE: begin
                if (bid >= nblocks) code = bsa_pkg::RC_BAD;
                else begin
                    status_tbl[bid] = bsa_pkg::ST_EMPTY;
                    ratio_tbl[bid] = '0;
                    b = bid;
                end
            end
            bsa_pkg::ACT_UNWR: begin
                for (int i = 0; i < nblocks; i++)
                    if (b < 0 && status_tbl[i] == bsa_pkg::ST_APPEND && !writing[i]) b = i;
                if (b < 0) begin
                    b = take_block(1'b1, mem);
                    if (b >= 0) status_tbl[b] = bsa_pkg::ST_APPEND;
                end
                if (b >= 0) writing[b] = 1'b1;
            end
            bsa_pkg::ACT_APPEND: begin
                b = next_append(1'b0, 0);
                if (b < 0) b = take_block(1'b1, mem);
                if (b >= 0) begin
                    status_tbl[b] = bsa_pkg::ST_APPEND;
                    rot_start = b;
                end
            end
            bsa_pkg::ACT_SLOT: begin
                n = active_slots();
                if (slot >= n) code = bsa_pkg::RC_BAD;
                else begin
                    // cached block survives only while still an append block
                    if (slot_vld[slot] && slot_blk[slot] < nblocks
                            && status_tbl[slot_blk[slot]] == bsa_pkg::ST_APPEND) begin
                        b = slot_blk[slot];
                    end else begin
                        slot_vld[slot] = 1'b0;
                        b = next_append(1'b1, n);
                        if (b < 0) begin
                            b = take_block(1'b1, mem);
                            if (b >= 0) begin
                                status_tbl[b] = bsa_pkg::ST_APPEND;
                                rot_start = b;
                            end
                        end
                        if (b >= 0) begin
                            slot_blk[slot] = b;
                            slot_vld[slot] = 1'b1;
                        end
                    end
                end
            end
            bsa_pkg::ACT_MFROM: begin
                b = first_with(bsa_pkg::ST_MFROM);
                if (b < 0) begin
                    least = bsa_pkg::RATIO_MAX;
                    pick = -1;
                    for (int i = 0; i < nblocks; i++)
                        if (status_tbl[i] == bsa_pkg::ST_FULL && ratio_tbl[i] <= least) begin
                            least = ratio_tbl[i];
                            pick = i;
                        end
                    if (pick >= 0 && ratio_tbl[pick] < bsa_pkg::RATIO_LIM) begin
                        status_tbl[pick] = bsa_pkg::ST_MFROM;
                        b = pick;
                    end
                end
            end
            bsa_pkg::ACT_MTO: begin
                b = first_with(bsa_pkg::ST_MTO);
                if (b < 0) begin
                    b = take_block(1'b0, mem);
                    if (b >= 0) status_tbl[b] = bsa_pkg::ST_MTO;
                end
            end
            bsa_pkg::ACT_CLRW: begin
                for (int i = 0; i < nblocks; i++) writing[i] = 1'b0;
                code = bsa_pkg::RC_OK;
            end
            bsa_pkg::ACT_UPDATE: begin
                if (bid >= nblocks || nst > bsa_pkg::ST_MTO) code = bsa_pkg::RC_BAD;
                else begin
                    status_tbl[bid] = nst;
                    ratio_tbl[bid] = (ratio > bsa_pkg::RATIO_MAX) ? bsa_pkg::RATIO_MAX : ratio;
                    b = bid;
                end
            end
            default: ;
        endcase
        if (b >= 0) return {1'b0, nblocks, 6'(b), bsa_pkg::RC_OK};
        return {1'b0, nblocks, 6'd0, code};
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        logic [15:0] exp_r;
        if (!i_rst_n) begin
            slot_reg <= 4'd2;
            nblocks = '0;
            rot_start = '0;
            for (int i = 0; i < bsa_pkg::MAX_BLOCKS; i++) begin
                status_tbl[i] = bsa_pkg::ST_EMPTY;
                writing[i] = 1'b0;
                ratio_tbl[i] = '0;
            end
            for (int i = 0; i < bsa_pkg::MAX_SLOTS; i++) begin
                slot_blk[i] = '0;
                slot_vld[i] = 1'b0;
            end
            expected_results.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_we) slot_reg <= i_cfg_wdata;
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transfer %h", $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r[1:0] !== i_out_data[1:0] || exp_r[7:2] !== i_out_data[7:2]
                            || exp_r[14:8] !== i_out_data[14:8]) begin
                        $display("%0t: mismatch code/index/count expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 $time, exp_r[1:0], exp_r[7:2], exp_r[14:8],
                                 i_out_data[1:0], i_out_data[7:2], i_out_data[14:8]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) expected_results.push_back(apply_action(i_in_data));
        end
    end
endmodule

/* tb/block_status_allocator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_status_allocator_tb
// Drives allocator actions through the input stream: a directed set of edge
// cases, then random phases with varying idle and stall rates and several
// slot-register settings. A checker module predicts and compares results.
// ----------------------------------------------------------------------------
module block_status_allocator_tb;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // action[3:0], block_id[9:4], slot[12:10], mem_enough[13], new_status[16:14],
    // use_ratio[23:17]
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // result_code[1:0], block_index[7:2], block_count[14:8]
    logic [15:0] m_axis_tdata;

    int  errors, pending, results;
    int  idle_pct = 0, stall_pct = 0, quiet_cycles = 0, sent = 0, settings = 0;
    bit  rx_hold = 1'b0;
    logic in_done = 1'b0, out_done = 1'b0;

    always #5 i_clk = ~i_clk;

    block_status_allocator i_dut (.*);

    block_status_allocator_checker i_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always @(posedge i_clk) begin
        in_done <= s_axis_tvalid && s_axis_tready;
        out_done <= m_axis_tvalid && m_axis_tready;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);

    function automatic logic [23:0] pack_action(logic [3:0] act, logic [5:0] bid,
            logic [2:0] slot, logic mem, logic [2:0] nst, logic [6:0] ratio);
        return {ratio, nst, mem, slot, bid, act};
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_action(logic [23:0] d);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do @(negedge i_clk); while (!in_done);
        sent++;
    endtask

    task automatic send_random();
        int w;
        logic [3:0] act;
        logic [5:0] bid;
        w = $urandom_range(99);
        if (w < 14) act = bsa_pkg::ACT_ALLOC;
        else if (w < 22) act = bsa_pkg::ACT_FREE;
        else if (w < 30) act = bsa_pkg::ACT_UNWR;
        else if (w < 40) act = bsa_pkg::ACT_APPEND;
        else if (w < 55) act = bsa_pkg::ACT_SLOT;
        else if (w < 63) act = bsa_pkg::ACT_MFROM;
        else if (w < 68) act = bsa_pkg::ACT_MTO;
        else if (w < 71) act = bsa_pkg::ACT_CLRW;
        else if (w < 96) act = bsa_pkg::ACT_UPDATE;
        else act = 4'($urandom_range(15, 9));
        bid = $urandom_range(1) ? 6'($urandom_range(15)) : 6'($urandom_range(63));
        send_action(pack_action(act, bid, 3'($urandom_range(7)),
                                $urandom_range(9) != 0,
                                $urandom_range(7) == 0 ? 3'($urandom_range(7))
                                                       : 3'($urandom_range(4)),
                                $urandom_range(9) == 0 ? 7'($urandom_range(127))
                                                       : 7'($urandom_range(100))));
    endtask

    task automatic drain_and_set(logic [3:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (700) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    initial begin
        logic [3:0] slot_vals [6];
        slot_vals = '{4'd0, 4'd8, 4'd15, 4'd5, 4'd1, 4'd3};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed edge cases on an empty table
        send_action(pack_action(bsa_pkg::ACT_ALLOC, 0, 0, 0, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_FREE, 0, 0, 1, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_APPEND, 0, 0, 0, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_ALLOC, 0, 0, 1, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_ALLOC, 0, 0, 1, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_UPDATE, 0, 0, 0, bsa_pkg::ST_FULL, 7'd127));
        send_action(pack_action(bsa_pkg::ACT_MFROM, 0, 0, 0, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_ALLOC, 0, 0, 1, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_UPDATE, 1, 0, 0, bsa_pkg::ST_FULL, 7'd99));
        send_action(pack_action(bsa_pkg::ACT_MFROM, 0, 0, 0, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_UPDATE, 0, 0, 0, bsa_pkg::ST_FULL, 7'd40));
        send_action(pack_action(bsa_pkg::ACT_UPDATE, 1, 0, 0, bsa_pkg::ST_FULL, 7'd40));
        send_action(pack_action(bsa_pkg::ACT_MFROM, 0, 0, 0, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_MFROM, 0, 0, 0, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_UPDATE, 0, 0, 0, 3'd7, 7'd10));
        send_action(pack_action(bsa_pkg::ACT_UPDATE, 6'd63, 0, 0, bsa_pkg::ST_FULL, 7'd10));
        send_action(pack_action(bsa_pkg::ACT_MTO, 0, 0, 0, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_MTO, 0, 0, 0, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_UNWR, 0, 0, 1, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_UNWR, 0, 0, 1, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_CLRW, 0, 0, 0, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_SLOT, 0, 0, 1, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_SLOT, 0, 1, 1, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_SLOT, 0, 7, 1, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_APPEND, 0, 0, 1, 0, 0));
        send_action(pack_action(bsa_pkg::ACT_FREE, 3, 0, 0, 0, 0));
        send_action(pack_action(4'd15, 0, 0, 1, 0, 0));

        for (int ph = 0; ph < 6; ph++) begin
            drain_and_set(slot_vals[ph]);
            idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 83 : 0;
            stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? 83 : 0;
            if (ph % 4 == 3) begin
                idle_pct = 12;
                stall_pct = 12;
            end
            if (ph == 0) begin
                // long output hold-off while the sender keeps offering input
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (3000) @(negedge i_clk);
                        rx_hold = 1'b0;
                    end
                    repeat (30) send_random();
                join
                repeat (60) send_random();
            end else begin
                repeat (88) send_random();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (700) @(negedge i_clk);
        $display("Covered %0d actions, %0d results, %0d slot-register settings",
                 sent, results, settings);
        $display("Idle/stall phases: none, sender 83%%, receiver 83%%, both 12%%");
        if (errors == 0 && results == sent)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
